// ===== design/nms_pkg.sv =====
// Package for the node mobility step block: widths, register indexes and
// the per-axis helper functions shared by the block. No dependencies.
`default_nettype none

package nms_pkg;

  // Table and coordinate geometry
  localparam int NODES      = 64;
  localparam int NODE_BITS  = $clog2(NODES);
  localparam int COORD_BITS = 12;
  localparam int DIR_BITS   = 4;

  // Rule constants
  localparam int KEEP_LIMIT = 67;
  localparam int DRAW_MAX   = 99;
  localparam int PERCENT    = 100;
  localparam int DIRS       = 8;

  // Configuration register indexes
  localparam logic [1:0] REG_MOVE_PROB = 2'd0;
  localparam logic [1:0] REG_AREA_SIZE = 2'd1;
  localparam logic [1:0] REG_WP_MODE   = 2'd2;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_MOVE = 1'b1;

  // Axis step codes for the walk directions
  localparam logic [1:0] AX_ZERO = 2'd0;
  localparam logic [1:0] AX_POS  = 2'd1;
  localparam logic [1:0] AX_NEG  = 2'd2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [DIR_BITS-1:0]   dir_t;

  // One table entry: position, waypoint and last direction
  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t wx;
    coord_t wy;
    dir_t   hd;
  } entry_t;

  // Latched input word
  typedef struct packed {
    logic       kind;
    logic [5:0] node;
    coord_t     load_x;
    coord_t     load_y;
    dir_t       load_dir;
    logic [6:0] move_draw;
    logic [6:0] keep_draw;
    logic [2:0] dir_draw;
    coord_t     wp_x_draw;
    coord_t     wp_y_draw;
  } item_t;

  // Clamp a coordinate into 1..s
  function automatic coord_t clamp_coord(coord_t v, coord_t s);
    coord_t r;
    if (v < coord_t'(1)) begin
      r = coord_t'(1);
    end else if (v > s) begin
      r = s;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // x step of directions 1..8: -1 0 +1 +1 +1 0 -1 -1
  function automatic logic [1:0] dir_dx(dir_t d);
    logic [1:0] r;
    case (d)
      4'd1, 4'd7, 4'd8: r = AX_NEG;
      4'd3, 4'd4, 4'd5: r = AX_POS;
      default:          r = AX_ZERO;
    endcase
    return r;
  endfunction

  // y step of directions 1..8: +1 +1 +1 0 -1 -1 -1 0
  function automatic logic [1:0] dir_dy(dir_t d);
    logic [1:0] r;
    case (d)
      4'd1, 4'd2, 4'd3: r = AX_POS;
      4'd5, 4'd6, 4'd7: r = AX_NEG;
      default:          r = AX_ZERO;
    endcase
    return r;
  endfunction

  // One walk step on an axis; returns {edge hit, new coordinate}
  function automatic logic [COORD_BITS:0] walk_axis(coord_t c, logic [1:0] a, coord_t s);
    logic   hit;
    coord_t r;
    hit = 1'b0;
    r   = c;
    case (a)
      AX_POS: begin
        if (c >= s) begin
          r   = s;
          hit = 1'b1;
        end else begin
          r = c + coord_t'(1);
        end
      end
      AX_NEG: begin
        if (c < coord_t'(2)) begin
          r   = coord_t'(1);
          hit = 1'b1;
        end else begin
          r = c - coord_t'(1);
        end
      end
      default: begin
        r = c;
      end
    endcase
    return {hit, r};
  endfunction

  // One step toward a target coordinate
  function automatic coord_t toward(coord_t c, coord_t t);
    coord_t r;
    if (c < t) begin
      r = c + coord_t'(1);
    end else if (c > t) begin
      r = c - coord_t'(1);
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/node_mobility_step_top.sv =====
// Node mobility step: node table in a synchronous RAM with read-modify-write.
// The accepting edge registers the item and the RAM read; the exec state then loads the
// result register and the strobe. Busy holds off start in the update cycle, so no new item
// is taken before the last is written back and the next read always sees that entry.
// Reset clears config to defaults and the per-entry valid bits; an entry not yet
// written reads as position, waypoint and direction all 1. No clearing pass.
// Results come as a one-cycle strobe; the receiver cannot stall.
`default_nettype none

module node_mobility_step_top (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write port
  input  wire logic                     cfg_we_i,
  input  wire logic [1:0]               cfg_idx_i,
  input  wire logic [11:0]              cfg_wdata_i,
  // command side
  input  wire logic                     start_i,
  output      logic                     busy_o,
  input  wire logic                     kind_i,
  input  wire logic [5:0]               node_index_i,
  input  wire nms_pkg::coord_t          load_x_i,
  input  wire nms_pkg::coord_t          load_y_i,
  input  wire nms_pkg::dir_t            load_direction_i,
  input  wire logic [6:0]               move_draw_i,
  input  wire logic [6:0]               keep_draw_i,
  input  wire logic [2:0]               direction_draw_i,
  input  wire nms_pkg::coord_t          waypoint_x_draw_i,
  input  wire nms_pkg::coord_t          waypoint_y_draw_i,
  // result side
  output      logic                     out_valid_o,
  output      logic [5:0]               out_node_o,
  output      nms_pkg::coord_t          out_x_o,
  output      nms_pkg::coord_t          out_y_o,
  output      nms_pkg::dir_t            out_direction_o,
  output      logic                     moved_o
);
  import nms_pkg::*;

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EXEC = 1'b1;

  // Configuration registers
  logic [6:0] move_prob_q;
  coord_t     area_size_q;
  logic       wp_mode_q;

  // Control
  logic [0:0] state_q, state_d;
  logic       accept;
  logic [NODES-1:0] valid_q;

  // Item and RAM read data
  item_t  item_q;
  entry_t rd_q;
  logic   rd_valid_q;
  entry_t mem [NODES];

  // Execute-stage signals
  entry_t cur;
  entry_t nxt;
  logic   node_ok;
  logic   moved;
  coord_t s;
  coord_t s_m1;
  coord_t wx_new, wy_new, tx, ty;
  logic [6:0] mv, kp, prob;
  dir_t   dir;
  logic [COORD_BITS:0] wax, way;
  logic [NODE_BITS-1:0] wr_addr;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q == ST_EXEC);
  assign wr_addr = item_q.node[NODE_BITS-1:0];

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_prob_q <= 7'd0;
      area_size_q <= coord_t'(100);
      wp_mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MOVE_PROB: move_prob_q <= cfg_wdata_i[6:0];
        REG_AREA_SIZE: area_size_q <= cfg_wdata_i[COORD_BITS-1:0];
        REG_WP_MODE:   wp_mode_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer: read on accept, modify and write back in the exec cycle
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_o <= (state_q == ST_EXEC);
      if ((state_q == ST_EXEC) && node_ok) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // Latch the input word and the entry valid bit
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind      <= kind_i;
      item_q.node      <= node_index_i;
      item_q.load_x    <= load_x_i;
      item_q.load_y    <= load_y_i;
      item_q.load_dir  <= load_direction_i;
      item_q.move_draw <= move_draw_i;
      item_q.keep_draw <= keep_draw_i;
      item_q.dir_draw  <= direction_draw_i;
      item_q.wp_x_draw <= waypoint_x_draw_i;
      item_q.wp_y_draw <= waypoint_y_draw_i;
      rd_valid_q       <= valid_q[node_index_i[NODE_BITS-1:0]];
    end
  end

  // Node RAM: registered read on accept, write back in the exec cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem[node_index_i[NODE_BITS-1:0]];
    end
    if ((state_q == ST_EXEC) && node_ok) begin
      mem[wr_addr] <= nxt;
    end
  end

  // Update of one node
  always_comb begin
    node_ok = (32'(item_q.node) < NODES);
    s       = (area_size_q == '0) ? coord_t'(1) : area_size_q;
    s_m1    = s - coord_t'(1);

    // never-written entries read as the reset value
    if (rd_valid_q) begin
      cur = rd_q;
    end else begin
      cur.px = coord_t'(1);
      cur.py = coord_t'(1);
      cur.wx = coord_t'(1);
      cur.wy = coord_t'(1);
      cur.hd = dir_t'(1);
    end

    mv     = (item_q.move_draw > 7'(DRAW_MAX)) ? 7'(DRAW_MAX) : item_q.move_draw;
    kp     = (item_q.keep_draw > 7'(DRAW_MAX)) ? 7'(DRAW_MAX) : item_q.keep_draw;
    prob   = (move_prob_q > 7'(PERCENT)) ? 7'(PERCENT) : move_prob_q;
    wx_new = ((item_q.wp_x_draw > s_m1) ? s_m1 : item_q.wp_x_draw) + coord_t'(1);
    wy_new = ((item_q.wp_y_draw > s_m1) ? s_m1 : item_q.wp_y_draw) + coord_t'(1);
    dir    = (kp < 7'(KEEP_LIMIT)) ? cur.hd : dir_t'({1'b0, item_q.dir_draw}) + dir_t'(1);
    tx     = cur.wx;
    ty     = cur.wy;
    wax    = '0;
    way    = '0;
    moved  = 1'b0;
    nxt    = cur;

    if (item_q.kind == KIND_LOAD) begin
      nxt.px = clamp_coord(item_q.load_x, s);
      nxt.py = clamp_coord(item_q.load_y, s);
      nxt.wx = nxt.px;
      nxt.wy = nxt.py;
      if (item_q.load_dir < dir_t'(1)) begin
        nxt.hd = dir_t'(1);
      end else if (item_q.load_dir > dir_t'(DIRS)) begin
        nxt.hd = dir_t'(DIRS);
      end else begin
        nxt.hd = item_q.load_dir;
      end
    end else if (mv < prob) begin
      moved = 1'b1;
      if (wp_mode_q) begin
        // new waypoint on arrival, then one cell toward it per axis
        if ((cur.px == cur.wx) && (cur.py == cur.wy)) begin
          tx = wx_new;
          ty = wy_new;
        end
        nxt.wx = tx;
        nxt.wy = ty;
        nxt.px = toward(cur.px, tx);
        nxt.py = toward(cur.py, ty);
      end else begin
        // persistent walk; an edge hit rotates the stored direction
        nxt.hd = dir;
        if ((dir >= dir_t'(1)) && (dir <= dir_t'(DIRS))) begin
          wax    = walk_axis(cur.px, dir_dx(dir), s);
          way    = walk_axis(cur.py, dir_dy(dir), s);
          nxt.px = wax[COORD_BITS-1:0];
          nxt.py = way[COORD_BITS-1:0];
          if (wax[COORD_BITS] || way[COORD_BITS]) begin
            nxt.hd = (dir == dir_t'(DIRS)) ? dir_t'(1) : dir + dir_t'(1);
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      out_node_o <= item_q.node;
      if (node_ok) begin
        out_x_o         <= nxt.px;
        out_y_o         <= nxt.py;
        out_direction_o <= nxt.hd;
        moved_o         <= moved;
      end else begin
        out_x_o         <= '0;
        out_y_o         <= '0;
        out_direction_o <= '0;
        moved_o         <= 1'b0;
      end
    end
  end

  // Checks
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EXEC))
    else $error("accepted word did not enter exec");

  a_exec_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> (state_q == ST_IDLE) && out_valid_o)
    else $error("exec did not finish in one cycle with a result");

  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$past(out_valid_o))
    else $error("result strobe held for two cycles");

  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_x_o != '0) && (out_y_o != '0) &&
                    (out_direction_o != '0) && (out_direction_o <= dir_t'(DIRS)))
    else $error("result position or direction out of range");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for node_mobility_step_top: drives load and move words, predicts every
// result from a local node table and checks each result strobe in order.
// Depends on nms_pkg for widths, register indexes and item kinds.

module tb;
  import nms_pkg::*;

  localparam logic [1:0] REG_UNUSED  = 2'd3;  // index beyond the register list
  localparam int         STALL_LIMIT = 2000;  // cycles with no traffic before giving up
  localparam int         PHASE_WORDS = 165;

  // Expected result of one word
  typedef struct packed {
    logic [5:0] node;
    coord_t     x;
    coord_t     y;
    dir_t       dir;
    logic       moved;
  } node_report_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        cfg_we_i          = 1'b0;
  logic [1:0]  cfg_idx_i         = 2'd0;
  logic [11:0] cfg_wdata_i       = 12'd0;
  logic        start_i           = 1'b0;
  logic        kind_i            = 1'b0;
  logic [5:0]  node_index_i      = 6'd0;
  coord_t      load_x_i          = '0;
  coord_t      load_y_i          = '0;
  dir_t        load_direction_i  = '0;
  logic [6:0]  move_draw_i       = 7'd0;
  logic [6:0]  keep_draw_i       = 7'd0;
  logic [2:0]  direction_draw_i  = 3'd0;
  coord_t      waypoint_x_draw_i = '0;
  coord_t      waypoint_y_draw_i = '0;
  logic        busy_o;
  logic        out_valid_o;
  logic [5:0]  out_node_o;
  coord_t      out_x_o;
  coord_t      out_y_o;
  dir_t        out_direction_o;
  logic        moved_o;

  node_mobility_step_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .kind_i            (kind_i),
    .node_index_i      (node_index_i),
    .load_x_i          (load_x_i),
    .load_y_i          (load_y_i),
    .load_direction_i  (load_direction_i),
    .move_draw_i       (move_draw_i),
    .keep_draw_i       (keep_draw_i),
    .direction_draw_i  (direction_draw_i),
    .waypoint_x_draw_i (waypoint_x_draw_i),
    .waypoint_y_draw_i (waypoint_y_draw_i),
    .out_valid_o       (out_valid_o),
    .out_node_o        (out_node_o),
    .out_x_o           (out_x_o),
    .out_y_o           (out_y_o),
    .out_direction_o   (out_direction_o),
    .moved_o           (moved_o)
  );

  // Clock: period 4
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Local copy of the node table and the registers
  coord_t     pos_x   [NODES];
  coord_t     pos_y   [NODES];
  coord_t     way_x   [NODES];
  coord_t     way_y   [NODES];
  dir_t       heading [NODES];
  logic [6:0] move_pct;
  coord_t     area_reg;
  logic       waypoint_on;

  node_report_t pending_reports[$];
  int idle_pct      = 0;
  int words_sent    = 0;
  int reports_seen  = 0;
  int moves_seen    = 0;
  int mismatches    = 0;
  int stall_cycles  = 0;

  // Grid side in use: a zero size counts as one
  function automatic coord_t grid_side();
    coord_t s;
    s = (area_reg == '0) ? coord_t'(1) : area_reg;
    return s;
  endfunction

  // One step of a coordinate toward its waypoint
  function automatic coord_t nudge(coord_t c, coord_t t);
    coord_t r;
    r = c;
    if (c < t) begin
      r = c + coord_t'(1);
    end else if (c > t) begin
      r = c - coord_t'(1);
    end
    return r;
  endfunction

  // Apply one word to the local node table and return the node afterwards
  function automatic node_report_t advance_node(item_t w);
    coord_t       s;
    coord_t       cx;
    coord_t       cy;
    coord_t       tx;
    coord_t       ty;
    dir_t         d;
    logic [6:0]   mv;
    logic [6:0]   kp;
    logic [6:0]   pct;
    logic         hit;
    int           n;
    node_report_t r;
    n      = w.node;
    s      = grid_side();
    r      = '0;
    r.node = w.node;
    if (w.kind == KIND_LOAD) begin
      // load: clamp into the grid, waypoint follows the position
      cx = (w.load_x == '0) ? coord_t'(1) : ((w.load_x > s) ? s : w.load_x);
      cy = (w.load_y == '0) ? coord_t'(1) : ((w.load_y > s) ? s : w.load_y);
      d  = (w.load_dir == '0) ? dir_t'(1) :
           ((w.load_dir > DIRS) ? dir_t'(DIRS) : w.load_dir);
      pos_x[n]   = cx;
      pos_y[n]   = cy;
      way_x[n]   = cx;
      way_y[n]   = cy;
      heading[n] = d;
    end else begin
      mv  = (w.move_draw > DRAW_MAX) ? 7'(DRAW_MAX) : w.move_draw;
      kp  = (w.keep_draw > DRAW_MAX) ? 7'(DRAW_MAX) : w.keep_draw;
      pct = (move_pct > PERCENT) ? 7'(PERCENT) : move_pct;
      if (mv < pct) begin
        r.moved = 1'b1;
        if (waypoint_on) begin
          // arrived: pick a new waypoint, draws saturate at the grid edge
          if (pos_x[n] == way_x[n] && pos_y[n] == way_y[n]) begin
            tx       = (w.wp_x_draw > s - 1) ? s - coord_t'(1) : w.wp_x_draw;
            ty       = (w.wp_y_draw > s - 1) ? s - coord_t'(1) : w.wp_y_draw;
            way_x[n] = tx + coord_t'(1);
            way_y[n] = ty + coord_t'(1);
          end
          pos_x[n] = nudge(pos_x[n], way_x[n]);
          pos_y[n] = nudge(pos_y[n], way_y[n]);
        end else begin
          // persistent walk: keep the last direction or take the drawn one
          d          = (kp < KEEP_LIMIT) ? heading[n] : dir_t'(w.dir_draw) + dir_t'(1);
          heading[n] = d;
          hit        = 1'b0;
          cx         = pos_x[n];
          cy         = pos_y[n];
          case (d)
            4'd1, 4'd7, 4'd8: begin
              if (cx < coord_t'(2)) begin
                cx  = coord_t'(1);
                hit = 1'b1;
              end else begin
                cx = cx - coord_t'(1);
              end
            end
            4'd3, 4'd4, 4'd5: begin
              if (cx >= s) begin
                cx  = s;
                hit = 1'b1;
              end else begin
                cx = cx + coord_t'(1);
              end
            end
            default: begin
            end
          endcase
          case (d)
            4'd5, 4'd6, 4'd7: begin
              if (cy < coord_t'(2)) begin
                cy  = coord_t'(1);
                hit = 1'b1;
              end else begin
                cy = cy - coord_t'(1);
              end
            end
            4'd1, 4'd2, 4'd3: begin
              if (cy >= s) begin
                cy  = s;
                hit = 1'b1;
              end else begin
                cy = cy + coord_t'(1);
              end
            end
            default: begin
            end
          endcase
          pos_x[n] = cx;
          pos_y[n] = cy;
          // edge hit turns the stored direction by one
          if (hit) begin
            heading[n] = (d == DIRS) ? dir_t'(1) : d + dir_t'(1);
          end
        end
      end
    end
    r.x   = pos_x[n];
    r.y   = pos_y[n];
    r.dir = heading[n];
    return r;
  endfunction

  function automatic item_t load_word(int n, int x, int y, int d);
    item_t w;
    w          = '0;
    w.kind     = KIND_LOAD;
    w.node     = 6'(n);
    w.load_x   = coord_t'(x);
    w.load_y   = coord_t'(y);
    w.load_dir = dir_t'(d);
    return w;
  endfunction

  function automatic item_t move_word(int n, int mv, int kp, int nd, int wx, int wy);
    item_t w;
    w           = '0;
    w.kind      = KIND_MOVE;
    w.node      = 6'(n);
    w.move_draw = 7'(mv);
    w.keep_draw = 7'(kp);
    w.dir_draw  = 3'(nd);
    w.wp_x_draw = coord_t'(wx);
    w.wp_y_draw = coord_t'(wy);
    return w;
  endfunction

  // Random word: mostly moves on a few hot nodes, mostly in-range fields
  function automatic item_t random_word();
    item_t  w;
    coord_t s;
    s           = grid_side();
    w.kind      = ($urandom_range(99) < 25) ? KIND_LOAD : KIND_MOVE;
    w.node      = ($urandom_range(3) != 0) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
    w.load_x    = ($urandom_range(9) < 7) ? coord_t'($urandom_range(s, 1)) : coord_t'($urandom());
    w.load_y    = ($urandom_range(9) < 7) ? coord_t'($urandom_range(s, 1)) : coord_t'($urandom());
    w.load_dir  = ($urandom_range(4) != 0) ? dir_t'($urandom_range(DIRS, 1))
                                           : dir_t'($urandom_range(15));
    w.move_draw = ($urandom_range(9) != 0) ? 7'($urandom_range(DRAW_MAX))
                                           : 7'($urandom_range(127, 100));
    w.keep_draw = ($urandom_range(9) != 0) ? 7'($urandom_range(DRAW_MAX))
                                           : 7'($urandom_range(127, 100));
    w.dir_draw  = 3'($urandom_range(7));
    w.wp_x_draw = ($urandom_range(4) != 0) ? coord_t'($urandom_range(s - 1)) : coord_t'($urandom());
    w.wp_y_draw = ($urandom_range(4) != 0) ? coord_t'($urandom_range(s - 1)) : coord_t'($urandom());
    return w;
  endfunction

  // Send one word: optional idle gap, then hold start until accepted
  task automatic send_word(input item_t w);
    int gap;
    gap = 0;
    while (gap < 12 && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i           <= 1'b1;
    kind_i            <= w.kind;
    node_index_i      <= w.node;
    load_x_i          <= w.load_x;
    load_y_i          <= w.load_y;
    load_direction_i  <= w.load_dir;
    move_draw_i       <= w.move_draw;
    keep_draw_i       <= w.keep_draw;
    direction_draw_i  <= w.dir_draw;
    waypoint_x_draw_i <= w.wp_x_draw;
    waypoint_y_draw_i <= w.wp_y_draw;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_reports.push_back(advance_node(w));
    words_sent++;
  endtask

  // Stop sending and wait until every expected result is in
  task automatic settle();
    start_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= 12'(value);
    @(posedge clk_i);
    case (idx)
      REG_MOVE_PROB: move_pct    = 7'(value);
      REG_AREA_SIZE: area_reg    = coord_t'(value);
      REG_WP_MODE:   waypoint_on = 1'(value);
      default: begin
      end
    endcase
  endtask

  // Write all registers while the block is idle; the unused index must not stick
  task automatic apply_settings(input int prob, input int area, input int mode);
    settle();
    write_reg(REG_MOVE_PROB, prob);
    write_reg(REG_AREA_SIZE, area);
    write_reg(REG_WP_MODE, mode);
    write_reg(REG_UNUSED, $urandom_range(4095));
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int pct, input int prob, input int area, input int mode);
    apply_settings(prob, area, mode);
    idle_pct = pct;
    repeat (PHASE_WORDS) send_word(random_word());
  endtask

  // Reset defaults: no moves, load clamping of position and direction
  task automatic test_load_clamps();
    send_word(move_word(9, 0, 0, 0, 0, 0));
    send_word(load_word(0, 0, 0, 0));
    send_word(load_word(63, 4095, 4095, 15));
    send_word(load_word(1, 50, 60, 9));
    send_word(load_word(2, 100, 1, 5));
    send_word(move_word(2, 0, 99, 3, 10, 10));
  endtask

  // All eight walk directions, keep versus new, edge clamps and turns
  task automatic test_walk_directions();
    apply_settings(127, 100, 0);
    send_word(load_word(4, 50, 50, 1));
    for (int d = 0; d < DIRS; d++) begin
      send_word(move_word(4, 127, 127, d, 0, 0));
    end
    // direction five at the lower edge clamps y and turns to six
    send_word(load_word(10, 1, 1, 2));
    send_word(move_word(10, 0, 67, 4, 0, 0));
    send_word(move_word(10, 99, 0, 0, 0, 0));
    // upper corner with a kept direction
    send_word(load_word(11, 4095, 4095, 3));
    send_word(move_word(11, 50, 66, 7, 0, 0));
  endtask

  // Waypoint mobility at the smallest and the largest grid
  task automatic test_waypoint_extremes();
    apply_settings(100, 0, 1);
    send_word(move_word(12, 0, 0, 0, 4095, 4095));
    apply_settings(100, 4095, 1);
    send_word(load_word(13, 4095, 4095, 8));
    send_word(move_word(13, 99, 0, 0, 0, 0));
    send_word(move_word(13, 127, 127, 7, 4095, 4095));
  endtask

  task automatic test_random_walk();
    run_phase(0, 60, 8, 0);
    run_phase(49, 127, 1, 0);
    run_phase(35, 90, 4095, 0);
    run_phase(49, $urandom_range(127), $urandom_range(20, 2), 0);
  endtask

  task automatic test_random_waypoint();
    run_phase(0, 100, 5, 1);
    run_phase(49, 0, 4095, 1);
    run_phase(35, 75, 3, 1);
    run_phase(0, 50, 0, 1);
  endtask

  task automatic note_mismatch(input string what, input node_report_t want,
                               input node_report_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected node %0d x %0d y %0d dir %0d moved %0d,",
               what, want.node, want.x, want.y, want.dir, want.moved);
      $display("  got node %0d x %0d y %0d dir %0d moved %0d",
               got.node, got.x, got.y, got.dir, got.moved);
    end
  endtask

  // Result checker: each strobe against the oldest expectation
  always @(posedge clk_i) begin
    node_report_t got;
    node_report_t want;
    if (rst_ni && out_valid_o) begin
      got = {out_node_o, out_x_o, out_y_o, out_direction_o, moved_o};
      reports_seen++;
      if (moved_o === 1'b1) moves_seen++;
      if (pending_reports.size() == 0) begin
        note_mismatch("result with no word outstanding", '0, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.node !== want.node || got.x !== want.x || got.y !== want.y ||
            got.dir !== want.dir || got.moved !== want.moved) begin
          note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // Watchdog: cycles with neither an accepted word nor a result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || out_valid_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout after %0d idle cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < NODES; i++) begin
      pos_x[i]   = coord_t'(1);
      pos_y[i]   = coord_t'(1);
      way_x[i]   = coord_t'(1);
      way_y[i]   = coord_t'(1);
      heading[i] = dir_t'(1);
    end
    move_pct    = 7'd0;
    area_reg    = coord_t'(100);
    waypoint_on = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_clamps();
    test_walk_directions();
    test_waypoint_extremes();
    test_random_walk();
    test_random_waypoint();
    settle();
    $display("Sent %0d words, checked %0d results, %0d of them moves,", words_sent,
             reports_seen, moves_seen);
    $display("across walk and waypoint modes, grid sizes 0 to 4095 and idle rates 0-49%%.");
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/nms_pkg.sv
design/node_mobility_step_top.sv
tb/tb.sv
